FILE: rtl/rau_pkg.sv
// Package with the command, status and order codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4
    } t_cmd;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [1:0] ORDER_GREATER = 2'b01;
    localparam logic [1:0] ORDER_LESS    = 2'b11;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] num_a;
        logic [31:0] den_a;
        logic [31:0] num_b;
        logic [31:0] den_b;
    } t_in_word;

    typedef struct packed {
        logic [31:0] result_num;
        logic [30:0] result_den;
        logic [1:0]  order;
        logic [1:0]  status;
    } t_out_word;
endpackage
`default_nettype wire

FILE: rtl/rau_if.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none
interface rau_in_if;
    logic              valid;
    logic              ready;
    rau_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    rau_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier and divider.
`default_nettype none
// The block takes one word of two signed fractions and a command, and returns one
// result word: the sum, difference, product or quotient reduced to lowest terms with
// the sign on the numerator, or for compare the order of the two magnitudes. Status
// flags a zero denominator (or division by zero) and a result that does not fit in
// WIDTH signed bits. A 64-bit restoring divider, one quotient bit a cycle, is shared by
// every remainder step of Euclid's loop (up to about 92 steps on 63-bit values) and by
// the two final divisions by the GCD.
// The four magnitude products come from one 32 by 32 multiplier, one product a cycle.
// The block is not ready while a word is at work, and it accepts the next word as
// soon as the result register is free or is being read in the same cycle.
module rational_arithmetic_unit_core #(
    parameter int WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_COMBINE, S_GCD_START, S_DIV, S_GCD_STEP,
        S_RED_NUM, S_RED_DEN, S_CHECK, S_OUT
    } t_state;

    t_state      r_state;
    logic [2:0]  r_cmd;
    logic        r_sa, r_sb;
    logic [31:0] r_ma, r_mda, r_mb, r_mdb;
    logic [1:0]  r_mul_idx;
    logic [63:0] r_p [4];
    logic        r_neg;
    logic [63:0] r_mag, r_den;
    logic [63:0] r_x, r_y;
    // Shared divider.
    logic [63:0] r_dvd, r_dvs, r_quo;
    logic [64:0] r_rem;
    logic [6:0]  r_cnt;
    logic [1:0]  r_div_use;
    logic        r_valid;
    rau_pkg::t_out_word r_out;

    localparam logic [1:0] USE_GCD = 2'd0;
    localparam logic [1:0] USE_NUM = 2'd1;
    localparam logic [1:0] USE_DEN = 2'd2;
    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    function automatic logic [31:0] f_mag(input logic [31:0] v);
        f_mag = v[31] ? (32'd0 - v) : v;
    endfunction

    // One multiplier: operands chosen by the product index.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        unique case (r_mul_idx)
            2'd0: begin mul_a = r_ma; mul_b = r_mdb; end
            2'd1: begin mul_a = r_mb; mul_b = r_mda; end
            2'd2: begin mul_a = r_ma; mul_b = r_mb; end
            default: begin mul_a = r_mda; mul_b = r_mdb; end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    logic [64:0] rem_sh;
    assign rem_sh = {r_rem[63:0], r_dvd[63]};

    assign i_in.ready  = (r_state == S_IDLE) && (!r_valid || o_out.ready);
    assign o_out.valid = r_valid;
    assign o_out.data  = r_out;

    logic accept;
    assign accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && o_out.ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // The previous result leaves at this edge at the latest.
                        r_out     <= '0;
                        r_cmd     <= i_in.data.command;
                        r_ma      <= f_mag(i_in.data.num_a);
                        r_mda     <= f_mag(i_in.data.den_a);
                        r_mb      <= f_mag(i_in.data.num_b);
                        r_mdb     <= f_mag(i_in.data.den_b);
                        r_sa      <= i_in.data.num_a[31] ^ i_in.data.den_a[31];
                        r_sb      <= i_in.data.num_b[31] ^ i_in.data.den_b[31];
                        r_mul_idx <= 2'd0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p[r_mul_idx] <= mul_p;
                    r_mul_idx      <= r_mul_idx + 2'd1;
                    if (r_mul_idx == 2'd3) r_state <= S_COMBINE;
                end
                S_COMBINE: begin
                    r_state <= S_OUT;
                    if (r_cmd > 3'(rau_pkg::CMD_CMP)) begin
                        r_out.status <= rau_pkg::STATUS_OK;
                    end else if (r_mda == 32'd0 || r_mdb == 32'd0 ||
                                 (r_cmd == 3'(rau_pkg::CMD_DIV) && r_mb == 32'd0)) begin
                        r_out.status <= rau_pkg::STATUS_ZERO_DEN;
                    end else begin
                        unique case (rau_pkg::t_cmd'(r_cmd))
                            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                                r_den   <= r_p[3];
                                r_state <= S_GCD_START;
                                if (r_sa == (r_sb ^ (r_cmd == 3'(rau_pkg::CMD_SUB)))) begin
                                    r_neg <= r_sa;
                                    r_mag <= r_p[0] + r_p[1];
                                end else if (r_p[0] >= r_p[1]) begin
                                    r_neg <= r_sa;
                                    r_mag <= r_p[0] - r_p[1];
                                end else begin
                                    r_neg <= !r_sa;
                                    r_mag <= r_p[1] - r_p[0];
                                end
                            end
                            rau_pkg::CMD_MUL: begin
                                r_neg <= r_sa ^ r_sb; r_mag <= r_p[2]; r_den <= r_p[3];
                                r_state <= S_GCD_START;
                            end
                            rau_pkg::CMD_DIV: begin
                                r_neg <= r_sa ^ r_sb;
                                r_mag <= r_p[0]; r_den <= r_p[1];
                                r_state <= S_GCD_START;
                            end
                            default: begin
                                r_out.order <= (r_p[0] > r_p[1]) ? rau_pkg::ORDER_GREATER :
                                               (r_p[0] < r_p[1]) ? rau_pkg::ORDER_LESS :
                                               rau_pkg::ORDER_EQUAL;
                            end
                        endcase
                    end
                end
                S_GCD_START: begin
                    if (r_mag == 64'd0) begin
                        r_out.result_den <= 31'd1;
                        r_state <= S_OUT;
                    end else begin
                        r_x <= r_mag;
                        r_y <= r_den;
                        r_state <= S_GCD_STEP;
                    end
                end
                S_GCD_STEP: begin
                    if (r_y == 64'd0) begin
                        r_dvd <= r_mag; r_dvs <= r_x; r_rem <= '0; r_cnt <= 7'd0;
                        r_div_use <= USE_NUM; r_state <= S_DIV;
                    end else begin
                        r_dvd <= r_x; r_dvs <= r_y; r_rem <= '0; r_cnt <= 7'd0;
                        r_div_use <= USE_GCD; r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (rem_sh >= {1'b0, r_dvs}) begin
                        r_rem <= rem_sh - {1'b0, r_dvs};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    if (r_cnt == 7'd63) begin
                        unique case (r_div_use)
                            USE_GCD: r_state <= S_RED_NUM;
                            USE_NUM: r_state <= S_RED_DEN;
                            default: r_state <= S_CHECK;
                        endcase
                    end
                end
                S_RED_NUM: begin
                    // Euclid step done: remainder is in r_rem.
                    r_x <= r_y;
                    r_y <= r_rem[63:0];
                    r_state <= S_GCD_STEP;
                end
                S_RED_DEN: begin
                    r_mag <= r_quo;
                    r_dvd <= r_den; r_dvs <= r_x; r_rem <= '0; r_cnt <= 7'd0;
                    r_div_use <= USE_DEN; r_state <= S_DIV;
                end
                S_CHECK: begin
                    r_state <= S_OUT;
                    if (r_quo > LIM - 64'd1 || (r_neg ? (r_mag > LIM) : (r_mag > LIM - 64'd1))) begin
                        r_out.status <= rau_pkg::STATUS_OVERFLOW;
                    end else begin
                        r_out.result_num <= r_neg ? (32'd0 - r_mag[31:0]) : r_mag[31:0];
                        r_out.result_den <= r_quo[30:0];
                    end
                end
                default: begin
                    if (!r_valid || o_out.ready) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rau_checker.sv
// Port checker for the rational arithmetic unit, bound to the top level.
`default_nettype none
module rau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [66:0] i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after accept");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data[1:0] != 2'd3)
        else $error("invalid status code");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[1:0] != rau_pkg::STATUS_OK |-> i_out_data[66:2] == '0)
        else $error("error result carries data");
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_data(o_out.data)
);
`default_nettype wire
